/* rtl/core/grle_pkg.sv */
// ----------------------------------------------------------------------------
// grle_pkg
// Shared types and constants of the graphics run-length decoder: status
// codes, flag byte fields and the command and status groups that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package grle_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned DimW    = 16;
  localparam int unsigned RunW    = 14;
  localparam int unsigned TotalW  = 32;
  localparam int unsigned StatusW = 3;

  // Flags byte fields
  localparam logic [ByteW-1:0] FlagLenMask  = 8'h3F;
  localparam logic [ByteW-1:0] FlagLowByte  = 8'h40;
  localparam logic [ByteW-1:0] FlagColor    = 8'h80;
  localparam logic [ByteW-1:0] EscapeByte   = 8'h00;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_MISALIGNED = 3'd1,
    ST_TOO_FEW    = 3'd2,
    ST_TOO_MANY   = 3'd3,
    ST_TRUNCATED  = 3'd4
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // take the input word this cycle
    logic div_start;  // launch the line-end remainder check
    logic load_out;   // move the held result into the output register
    logic clear;      // return decode state to its reset value
  } grle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic result_in;    // the offered word yields a result
    logic line_end_in;  // that result is an end of line
    logic div_busy;     // remainder unit still iterating
    logic out_free;     // output register can take a result
    logic hold_last;    // held result closes the picture
  } grle_sts_t;

endpackage

/* rtl/core/grle_if.sv */
// ----------------------------------------------------------------------------
// grle_in_if / grle_out_if
// Valid/ready channels of the decoder: coded byte input and decoded run
// output.
// ----------------------------------------------------------------------------
interface grle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface grle_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  color_index;
  logic [13:0] run_length;
  logic        line_end;
  logic        final_result;
  logic [2:0]  status;

  modport source (output valid, output color_index, output run_length, output line_end,
                  output final_result, output status, input ready);
  modport sink   (input valid, input color_index, input run_length, input line_end,
                  input final_result, input status, output ready);
endinterface

/* rtl/core/grle_rem.sv */
// ----------------------------------------------------------------------------
// grle_rem
// Iterative restoring remainder unit: pixel total modulo image width, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module grle_rem
  import grle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TotalW-1:0] dividend,
  input  logic [DimW-1:0]   divisor,
  output logic              busy,
  output logic              rem_zero
);

  localparam int unsigned CntW = $clog2(TotalW);

  logic [TotalW-1:0] quo_r;
  logic [DimW-1:0]   rem_r;
  logic [DimW-1:0]   div_r;
  logic [CntW-1:0]   cnt_r;
  logic              busy_r;
  logic [DimW:0]     shifted;
  logic [DimW:0]     diff;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem_r, quo_r[TotalW-1]};
    diff    = shifted - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      quo_r  <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[TotalW-2:0], 1'b0};
      if (shifted >= {1'b0, div_r}) begin
        rem_r <= diff[DimW-1:0];
      end else begin
        rem_r <= shifted[DimW-1:0];
      end
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CntW'(TotalW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign rem_zero = (rem_r == '0);

endmodule

/* rtl/core/grle_dp.sv */
// ----------------------------------------------------------------------------
// grle_dp
// Decoder datapath: header and code parsing, pixel total, expected count,
// held result, status and the output register.
// ----------------------------------------------------------------------------
module grle_dp
  import grle_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  grle_cmd_t        cmd,
  output grle_sts_t        sts,
  input  logic [ByteW-1:0] data_byte,
  input  logic             last_byte,
  grle_out_if.source       out_stream
);

  typedef enum logic [2:0] {
    PH_WIDTH_HI, PH_WIDTH_LO, PH_HEIGHT_HI, PH_HEIGHT_LO,
    PH_CODE, PH_FLAGS, PH_LEN_LO, PH_COLOR
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [DimW-1:0]   width_r, width_nxt;
  logic [DimW-1:0]   height_r, height_nxt;
  logic [RunW-1:0]   pend_r, pend_nxt;
  logic              cf_r, cf_nxt;
  logic [TotalW-1:0] total_r, total_nxt;
  logic [TotalW-1:0] product_r;
  logic [TotalW:0]   total_sum;

  logic              done;
  logic [ByteW-1:0]  color;
  logic [RunW-1:0]   run;

  logic [ByteW-1:0]  hold_color_r;
  logic [RunW-1:0]   hold_run_r;
  logic              hold_le_r;
  logic              hold_last_r;
  logic              hold_trunc_r;

  logic              out_valid_r;
  logic [ByteW-1:0]  out_color_r;
  logic [RunW-1:0]   out_run_r;
  logic              out_le_r;
  logic              out_final_r;
  status_t           out_status_r;
  status_t           status_nxt;

  logic              div_busy;
  logic              rem_zero;
  logic              aligned;

  // Decode one byte against the current phase
  always_comb begin
    phase_nxt  = phase_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    pend_nxt   = pend_r;
    cf_nxt     = cf_r;
    done       = 1'b0;
    color      = '0;
    run        = '0;
    unique case (phase_r)
      PH_WIDTH_HI: begin
        width_nxt = {data_byte, 8'h00};
        phase_nxt = PH_WIDTH_LO;
      end
      PH_WIDTH_LO: begin
        width_nxt = {width_r[DimW-1:ByteW], data_byte};
        phase_nxt = PH_HEIGHT_HI;
      end
      PH_HEIGHT_HI: begin
        height_nxt = {data_byte, 8'h00};
        phase_nxt  = PH_HEIGHT_LO;
      end
      PH_HEIGHT_LO: begin
        height_nxt = {height_r[DimW-1:ByteW], data_byte};
        phase_nxt  = PH_CODE;
      end
      PH_CODE: begin
        if (data_byte != EscapeByte) begin
          color = data_byte;
          run   = RunW'(1);
          done  = 1'b1;
        end else begin
          phase_nxt = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        pend_nxt = RunW'(data_byte & FlagLenMask);
        cf_nxt   = (data_byte & FlagColor) != '0;
        priority if ((data_byte & FlagLowByte) != '0) begin
          phase_nxt = PH_LEN_LO;
        end else if ((data_byte & FlagColor) != '0) begin
          phase_nxt = PH_COLOR;
        end else begin
          run  = RunW'(data_byte & FlagLenMask);
          done = 1'b1;
        end
      end
      PH_LEN_LO: begin
        pend_nxt = {pend_r[RunW-ByteW-1:0], data_byte};
        if (cf_r) begin
          phase_nxt = PH_COLOR;
        end else begin
          run  = {pend_r[RunW-ByteW-1:0], data_byte};
          done = 1'b1;
        end
      end
      PH_COLOR: begin
        color = data_byte;
        run   = pend_r;
        done  = 1'b1;
      end
      default: begin
        phase_nxt = PH_WIDTH_HI;
      end
    endcase
    if (done) begin
      phase_nxt = PH_CODE;
    end
  end

  // Saturating pixel total
  always_comb begin
    total_sum = {1'b0, total_r} + {{(TotalW + 1 - RunW){1'b0}}, run};
    if (done && run != '0) begin
      total_nxt = total_sum[TotalW] ? '1 : total_sum[TotalW-1:0];
    end else begin
      total_nxt = total_r;
    end
  end

  // Line end alignment and final status of the held result
  always_comb begin
    aligned = (width_r == '0) ? (total_r == '0) : rem_zero;
    priority if (hold_trunc_r) begin
      status_nxt = ST_TRUNCATED;
    end else if (hold_le_r && !aligned) begin
      status_nxt = ST_MISALIGNED;
    end else if (hold_last_r && total_r < product_r) begin
      status_nxt = ST_TOO_FEW;
    end else if (hold_last_r && total_r > product_r) begin
      status_nxt = ST_TOO_MANY;
    end else begin
      status_nxt = ST_OK;
    end
  end

  // Decode state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      phase_r  <= PH_WIDTH_HI;
      width_r  <= '0;
      height_r <= '0;
      pend_r   <= '0;
      cf_r     <= 1'b0;
      total_r  <= '0;
    end else if (cmd.accept) begin
      phase_r  <= phase_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      pend_r   <= pend_nxt;
      cf_r     <= cf_nxt;
      total_r  <= total_nxt;
    end
  end

  // Expected pixel count, registered from the header width and height
  always_ff @(posedge clk) begin
    product_r <= width_r * height_r;
  end

  // Hold the result of the accepted word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hold_last_r <= last_byte;
      if (last_byte && !done) begin
        hold_color_r <= '0;
        hold_run_r   <= '0;
        hold_le_r    <= 1'b0;
        hold_trunc_r <= 1'b1;
      end else begin
        hold_color_r <= color;
        hold_run_r   <= run;
        hold_le_r    <= done && (run == '0);
        hold_trunc_r <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_color_r  <= hold_color_r;
      out_run_r    <= hold_run_r;
      out_le_r     <= hold_le_r;
      out_final_r  <= hold_last_r;
      out_status_r <= status_nxt;
    end
  end

  grle_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (total_r),
    .divisor  (width_r),
    .busy     (div_busy),
    .rem_zero (rem_zero)
  );

  assign out_stream.valid        = out_valid_r;
  assign out_stream.color_index  = out_color_r;
  assign out_stream.run_length   = out_run_r;
  assign out_stream.line_end     = out_le_r;
  assign out_stream.final_result = out_final_r;
  assign out_stream.status       = out_status_r;

  assign sts.result_in   = done || last_byte;
  assign sts.line_end_in = done && (run == '0);
  assign sts.div_busy    = div_busy;
  assign sts.out_free    = !out_valid_r || out_stream.ready;
  assign sts.hold_last   = hold_last_r;

endmodule

/* rtl/core/grle_ctrl.sv */
// ----------------------------------------------------------------------------
// grle_ctrl
// Decoder controller: takes input words, waits on the remainder unit for
// line ends and hands results to the output register.
// ----------------------------------------------------------------------------
module grle_ctrl
  import grle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  grle_sts_t sts,
  output grle_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE, S_DIV, S_EMIT
  } state_t;

  state_t state_r;

  // Commands
  always_comb begin
    cmd.accept    = (state_r == S_IDLE) && in_valid;
    cmd.div_start = cmd.accept && sts.line_end_in;
    cmd.load_out  = (state_r == S_EMIT) && sts.out_free;
    cmd.clear     = cmd.load_out && sts.hold_last;
  end

  assign in_ready = (state_r == S_IDLE);

  // Sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd.accept) begin
            priority if (sts.line_end_in) begin
              state_r <= S_DIV;
            end else if (sts.result_in) begin
              state_r <= S_EMIT;
            end
          end
        end
        S_DIV: begin
          if (!sts.div_busy) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/graphics_rle_decoder_unit.sv */
// ----------------------------------------------------------------------------
// graphics_rle_decoder_unit
// Run-length decoder for graphics object pictures: header, runs and count
// checks, one result word per completed code or truncated final byte.
// ----------------------------------------------------------------------------
// A header byte or a code byte that completes no run is only taken. A byte
// that completes a run is taken, then loaded into the output register once
// it is free; the register then holds the word while the next byte comes in.
// An end-of-line code also waits on the remainder unit, which checks line
// alignment one bit of the 32-bit pixel total per cycle. Errors
// are reported in the status field and decoding continues; after the final
// byte the decoder expects a new header.
module graphics_rle_decoder_unit
  import grle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  grle_in_if.sink    in_stream,
  grle_out_if.source out_stream
);

  grle_cmd_t cmd;
  grle_sts_t sts;
  logic      in_ready;

  grle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_stream.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  grle_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .data_byte  (in_stream.data_byte),
    .last_byte  (in_stream.last_byte),
    .out_stream (out_stream)
  );

  assign in_stream.ready = in_ready;

  // Never load over a word that is still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("output register overwritten");

  // A word that yields a result closes the input until it is loaded into the output register
  a_result_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.result_in) |=> !in_stream.ready)
    else $error("input taken while a result is pending");

  // A line end keeps the remainder unit busy on the next cycle
  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> sts.div_busy)
    else $error("remainder unit did not start");

endmodule
